// ===== src/pip_pkg.sv =====
// Package for the point-in-polygon test core: sizes, opcodes and the
// edge walker state type. No dependencies.
package pip_pkg;
  localparam int MaxVertices = 64;
  localparam int CoordBits   = 16;
  localparam int QueueDepth  = 2;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TEST = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_WALK,
    ST_DONE
  } walk_state_t;
endpackage

// ===== src/pip_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pip_ram #(
  parameter int Width = 16,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [Width-1:0]         wr_data,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

// ===== src/pip_front.sv =====
// Front part: accepts items; loads update the polygon store and box, tests go
// into a two-entry queue toward the edge walker. Uses pip_pkg.
module pip_front #(
  parameter int CoordBits = pip_pkg::CoordBits
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 op,
  input  logic [CoordBits-1:0] x,
  input  logic [CoordBits-1:0] y,
  output logic                 ld_en,
  output logic                 ld_start,
  output logic [CoordBits-1:0] ld_x,
  output logic [CoordBits-1:0] ld_y,
  output logic                 q_valid,
  input  logic                 q_ready,
  output logic [CoordBits-1:0] q_x,
  output logic [CoordBits-1:0] q_y,
  input  logic                 starts_polygon
);
  logic [CoordBits-1:0] qx [pip_pkg::QueueDepth];
  logic [CoordBits-1:0] qy [pip_pkg::QueueDepth];
  logic       wr_ptr, rd_ptr;
  logic [1:0] fill;
  logic       push, pop;

  // Loads must wait until all queued tests are done so they see the old polygon.
  assign in_ready = (op == pip_pkg::OP_LOAD) ? (fill == 2'd0 && q_ready)
                                             : (fill != 2'(pip_pkg::QueueDepth));
  assign push     = in_valid && in_ready && op == pip_pkg::OP_TEST;
  assign pop      = q_valid && q_ready;
  assign ld_en    = in_valid && in_ready && op == pip_pkg::OP_LOAD;
  assign ld_start = starts_polygon;
  assign ld_x     = x;
  assign ld_y     = y;
  assign q_valid  = fill != 2'd0;
  assign q_x      = qx[rd_ptr];
  assign q_y      = qy[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        qx[wr_ptr] <= x;
        qy[wr_ptr] <= y;
        wr_ptr     <= ~wr_ptr;
      end
      if (pop) rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// ===== src/pip_back.sv =====
// Back part: walks stored edges one per cycle for a queued test point and
// delivers the result through an output register. Uses pip_pkg, pip_ram.
module pip_back #(
  parameter int MaxVertices = pip_pkg::MaxVertices,
  parameter int CoordBits   = pip_pkg::CoordBits
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 ld_en,
  input  logic                 ld_start,
  input  logic [CoordBits-1:0] ld_x,
  input  logic [CoordBits-1:0] ld_y,
  input  logic                 q_valid,
  output logic                 q_ready,
  input  logic [CoordBits-1:0] q_x,
  input  logic [CoordBits-1:0] q_y,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 inside_res,
  output logic                 truncated
);
  localparam int AW = (MaxVertices > 1) ? $clog2(MaxVertices) : 1;
  localparam int CW = $clog2(MaxVertices + 1);
  localparam int CB = CoordBits;
  localparam int DW = CB + 2;          // signed differences
  localparam int PW = 2 * CB + 3;      // product width

  logic [CW-1:0] count;
  logic [CB-1:0] cmin, cmax, rmin, rmax;
  logic          ovf;

  // Polygon store, two copies so that vertex i and i+1 stream together.
  logic [2*CB-1:0] ram_a_q, ram_b_q;
  logic [AW-1:0]   ld_addr, rd_a, rd_b;
  logic [CW-1:0]   base;
  logic            can_add;

  assign base    = ld_start ? '0 : count;
  assign can_add = base < CW'(MaxVertices);
  assign ld_addr = AW'(base);

  pip_ram #(.Width(2 * CB), .Depth(MaxVertices)) u_ram_a (
    .clk, .wr_en(ld_en && can_add), .wr_addr(ld_addr), .wr_data({ld_x, ld_y}),
    .rd_addr(rd_a), .rd_data(ram_a_q));
  pip_ram #(.Width(2 * CB), .Depth(MaxVertices)) u_ram_b (
    .clk, .wr_en(ld_en && can_add), .wr_addr(ld_addr), .wr_data({ld_x, ld_y}),
    .rd_addr(rd_b), .rd_data(ram_b_q));

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      cmin <= '1; cmax <= '0; rmin <= '1; rmax <= '0;
      ovf <= 1'b0;
    end else if (ld_en) begin
      if (can_add) begin
        count <= base + CW'(1);
        cmin <= (ld_start || ld_x < cmin) ? ld_x : cmin;
        cmax <= (ld_start || ld_x > cmax) ? ld_x : cmax;
        rmin <= (ld_start || ld_y < rmin) ? ld_y : rmin;
        rmax <= (ld_start || ld_y > rmax) ? ld_y : rmax;
        ovf  <= ld_start ? 1'b0 : ovf;
      end else begin
        ovf <= 1'b1;
      end
    end
  end

  // Walker state.
  pip_pkg::walk_state_t state, state_next;
  logic [CB-1:0] px, py;
  logic [CW-1:0] idx;          // next edge index to issue
  logic [CB-1:0] prev_row;     // row of vertex before current edge start
  logic          odd, hit;
  logic          issue;        // read issued last cycle for an edge
  logic          last_issued;

  // Stage 2 registers (after multiply).
  logic          s2_v, s2_hit, s2_tog, s2_div;
  logic signed [PW-1:0] s2_num;
  logic signed [DW-1:0] s2_den;
  logic signed [DW-1:0] s2_x0, s2_x;
  // Divider pipeline output.
  logic          dv_v, dv_valid_t;

  assign q_ready = state == pip_pkg::ST_IDLE && !out_valid;

  // Read addresses: A reads vertex idx, B reads idx+1 mod n.
  logic [CW-1:0] nxt_i;
  assign nxt_i = (idx + CW'(1) == count) ? '0 : idx + CW'(1);
  assign rd_a  = AW'(idx);
  assign rd_b  = AW'(nxt_i);

  // Edge evaluation on stage 1 data.
  logic signed [DW-1:0] sx, sy, x0, y0, x1, y1, pr;
  logic e_hit, e_tog, e_div;
  always_comb begin
    sx = DW'(signed'({2'b0, px}));
    sy = DW'(signed'({2'b0, py}));
    x0 = DW'(signed'({2'b0, ram_a_q[2*CB-1:CB]}));
    y0 = DW'(signed'({2'b0, ram_a_q[CB-1:0]}));
    x1 = DW'(signed'({2'b0, ram_b_q[2*CB-1:CB]}));
    y1 = DW'(signed'({2'b0, ram_b_q[CB-1:0]}));
    pr = DW'(signed'({2'b0, prev_row}));
    e_hit = 1'b0; e_tog = 1'b0; e_div = 1'b0;
    if (x0 < sx && x1 < sx) begin
    end else if ((y0 < sy && y1 < sy) || (y0 > sy && y1 > sy)) begin
    end else if ((x0 == sx && y0 == sy) || (x1 == sx && y1 == sy)) begin
      e_hit = 1'b1;
    end else if (y0 == y1) begin
      e_hit = !(x0 > sx && x1 > sx);
    end else if (x0 == x1) begin
      e_tog = (sy != y0 && sy != y1);
    end else if (sy == y0) begin
      // previous and end vertex not strictly on the same side
      e_tog = (sx < x0) &&
              !((pr < sy && y1 < sy) || (pr > sy && y1 > sy));
    end else if (sy == y1) begin
    end else begin
      e_div = 1'b1;
    end
  end

  // Multiply stage: num = (y-y0)*(x1-x0), normalized to positive den.
  logic signed [DW-1:0] dy, dx, dn;
  logic signed [PW-1:0] prod;
  always_comb begin
    dy = sy - y0;
    dx = x1 - x0;
    dn = y1 - y0;
    prod = PW'(dy) * PW'(dx);
    if (dn < 0) begin
      prod = -prod;
      dn = -dn;
    end
  end

  always_ff @(posedge clk) begin
    s2_v   <= issue && !rst;
    s2_hit <= e_hit;
    s2_tog <= e_tog;
    s2_div <= e_div;
    s2_num <= prod;
    s2_den <= dn;
    s2_x0  <= x0;
    s2_x   <= sx;
  end

  // Pipelined restoring floor divider, one quotient bit per stage.
  localparam int QW = PW;
  logic [QW:0]         dvv;
  logic [QW:0]         dhit, dtog, ddiv, dneg;
  logic [PW-1:0]       drem [QW+1];
  logic [QW-1:0]       dq   [QW+1];
  logic [DW-1:0]       dden [QW+1];
  logic signed [DW-1:0] dx0 [QW+1], dxx [QW+1];

  always_ff @(posedge clk) begin
    if (rst) dvv <= '0;
    else dvv <= {dvv[QW-1:0], s2_v};
  end

  always_ff @(posedge clk) begin
    dhit[0] <= s2_hit; dtog[0] <= s2_tog; ddiv[0] <= s2_div;
    dneg[0] <= s2_num < 0;
    drem[0] <= (s2_num < 0) ? PW'(-s2_num) : PW'(s2_num);
    dq[0]   <= '0;
    dden[0] <= s2_den;
    dx0[0]  <= s2_x0;
    dxx[0]  <= s2_x;
  end

  for (genvar k = 0; k < QW; k++) begin : g_div
    localparam int B = QW - 1 - k;
    logic [2*PW-1:0] sh;
    assign sh = {{PW{1'b0}}, PW'(dden[k])} << B;
    always_ff @(posedge clk) begin
      dhit[k+1] <= dhit[k]; dtog[k+1] <= dtog[k]; ddiv[k+1] <= ddiv[k];
      dneg[k+1] <= dneg[k]; dden[k+1] <= dden[k];
      dx0[k+1] <= dx0[k]; dxx[k+1] <= dxx[k];
      if ({{PW{1'b0}}, drem[k]} >= sh) begin
        drem[k+1] <= drem[k] - PW'(sh);
        dq[k+1]   <= dq[k] | (QW'(1) << B);
      end else begin
        drem[k+1] <= drem[k];
        dq[k+1]   <= dq[k];
      end
    end
  end

  // Final: floor for negative numerators, then compare.
  logic signed [PW:0] fq, cx;
  logic f_hit, f_tog;
  always_comb begin
    fq = dneg[QW] ? -($signed({1'b0, dq[QW]}) + (PW+1)'((drem[QW] != '0) ? 1 : 0))
                  : $signed({1'b0, dq[QW]});
    cx = fq + (PW+1)'(dx0[QW]);
    f_hit = dhit[QW] || (ddiv[QW] && cx == (PW+1)'(dxx[QW]));
    f_tog = dtog[QW] || (ddiv[QW] && cx > (PW+1)'(dxx[QW]));
  end
  assign dv_v = dvv[QW];
  assign dv_valid_t = f_tog;

  // Control.
  logic start_ok;
  assign start_ok = count != '0 && q_x >= cmin && q_x <= cmax &&
                    q_y >= rmin && q_y <= rmax;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pip_pkg::ST_IDLE;
      out_valid <= 1'b0;
      issue <= 1'b0;
    end else begin
      state <= state_next;
      issue <= (state == pip_pkg::ST_WALK) && !last_issued;
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (q_valid && q_ready) begin
        px <= q_x; py <= q_y; idx <= count - CW'(1); odd <= 1'b0; hit <= 1'b0;
        last_issued <= 1'b0;
        truncated <= ovf;
        if (!start_ok) begin
          inside_res <= 1'b0;
          out_valid  <= 1'b1;
        end
      end
      if (state == pip_pkg::ST_READ) begin
        // vertex n-1 is read on A to seed the previous row; walk starts at 0
        idx <= '0;
      end
      if (state == pip_pkg::ST_WALK) begin
        // A holds vertex n-1 first, then each edge's start vertex
        prev_row <= ram_a_q[CB-1:0];
        if (!last_issued) begin
          if (idx == count - CW'(1)) last_issued <= 1'b1;
          idx <= nxt_i;
        end
      end
      if (dv_v) begin
        hit <= hit | f_hit;
        odd <= odd ^ dv_valid_t;
      end
      if (state == pip_pkg::ST_DONE && state_next == pip_pkg::ST_IDLE) begin
        inside_res <= hit | odd;
        out_valid  <= 1'b1;
      end
    end
  end

  // Drain counter: waits for divider pipe to empty after last edge.
  localparam int DrainW = $clog2(QW + 4);
  logic [DrainW-1:0] drain;
  always_ff @(posedge clk) begin
    if (state != pip_pkg::ST_DONE) drain <= '0;
    else drain <= drain + DrainW'(1);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      pip_pkg::ST_IDLE: if (q_valid && q_ready && start_ok) state_next = pip_pkg::ST_READ;
      pip_pkg::ST_READ: state_next = pip_pkg::ST_WALK;
      pip_pkg::ST_WALK: if (last_issued) state_next = pip_pkg::ST_DONE;
      pip_pkg::ST_DONE: if (drain == DrainW'(QW + 3)) state_next = pip_pkg::ST_IDLE;
      default: state_next = pip_pkg::ST_IDLE;
    endcase
  end
endmodule

// ===== src/point_in_polygon_test_core.sv =====
// Point-in-polygon test core. Load items (op=0) append one vertex to the
// polygon store (starts_polygon restarts it) and keep the bounding box; a
// vertex beyond MAX_VERTICES is dropped and flags truncated. Test items
// (op=1) give one result: inside_res=1 when the pixel lies on or inside the
// closed polygon, by even-odd ray casting with an exact integer crossing.
// A test outside the box or with no vertices has its result registered when
// the back end takes it from the queue; otherwise the back end streams one
// edge per cycle through a multiplier and a fully pipelined floor divider:
// the test waits in the queue, a read step seeds the previous row, the walk
// issues each edge, and a drain lets the multiply and divide stages empty
// before the result is registered. Loads wait until queued tests have
// finished and their results have been taken.
module point_in_polygon_test_core #(
  parameter int MAX_VERTICES = pip_pkg::MaxVertices,
  parameter int COORD_BITS   = pip_pkg::CoordBits
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  op,
  input  logic [COORD_BITS-1:0] x,
  input  logic [COORD_BITS-1:0] y,
  input  logic                  starts_polygon,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  inside_res,
  output logic                  truncated
);
  logic                  ld_en, ld_start, q_valid, q_ready;
  logic [COORD_BITS-1:0] ld_x, ld_y, q_x, q_y;

  // Front: classify item, queue tests.
  pip_front #(.CoordBits(COORD_BITS)) u_front (
    .clk, .rst, .in_valid, .in_ready, .op, .x, .y,
    .ld_en, .ld_start, .ld_x, .ld_y,
    .q_valid, .q_ready, .q_x, .q_y, .starts_polygon);

  // Back: polygon store and edge walker.
  pip_back #(.MaxVertices(MAX_VERTICES), .CoordBits(COORD_BITS)) u_back (
    .clk, .rst, .ld_en, .ld_start, .ld_x, .ld_y,
    .q_valid, .q_ready, .q_x, .q_y,
    .out_valid, .out_ready, .inside_res, .truncated);

  // A load never passes while a test waits in the queue.
  a_load_order: assert property (@(posedge clk) disable iff (rst)
    ld_en |-> !q_valid) else $error("load overtook queued test");

  // An unaccepted result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(inside_res))
    else $error("result dropped");
endmodule
